FILE: src/assert_macros.svh
// Assertion macros used by the stack controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Antecedent at one edge implies consequent at the next
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/bls_pkg.sv
// Types and constants of the bounded LIFO stack
`default_nettype none

package bls_pkg;

	localparam int WORD_W = 32;
	localparam int FIELD_W = 5;

	localparam logic [1:0] CMD_PUSH = 2'd0;
	localparam logic [1:0] CMD_POP  = 2'd1;
	localparam logic [1:0] CMD_PEEK = 2'd2;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_OVERFLOW = 2'd1;
	localparam logic [1:0] STAT_EMPTY    = 2'd2;
	localparam logic [1:0] STAT_BAD_POS  = 2'd3;

	localparam logic [FIELD_W-1:0] CAP_RESET = 5'd16;

	typedef struct packed {
		logic [1:0]               command;
		logic signed [WORD_W-1:0] push_value;
		logic [FIELD_W-1:0]       depth_position;
	} cmd_word_t;

	typedef struct packed {
		logic [1:0]               status;
		logic signed [WORD_W-1:0] read_data;
		logic [FIELD_W-1:0]       entry_count;
	} rsp_word_t;

	// per-cycle control broadcast to every cell
	typedef struct packed {
		logic push;
		logic pop;
		logic load_tap;
		logic shift_tap;
	} cell_ctl_t;

	typedef enum logic {
		S_IDLE,
		S_PEEK
	} state_t;

endpackage

`default_nettype wire

FILE: src/bounded_lifo_stack.sv
// Top level of the bounded LIFO stack: a row of cells and its controller
// Results: push, pop, no-op and rejected words give their result in the cycle after acceptance;
//   a peek at position p gives its result once the tap row walk has brought that word to the top.
// Throughput: one push or pop per cycle while the result side keeps up; a peek stalls new
//   words until its result is loaded, the tap row moving one cell towards the top per cycle.
// Reset: arst_n clears the fill count, the controller state and the result valid,
//   and sets capacity to 16; the stored words are not cleared.
`default_nettype none

module bounded_lifo_stack import bls_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cmd_valid,
	output logic                    cmd_stall,
	input  wire cmd_word_t          cmd_word,
	output logic                    rsp_valid,
	input  wire logic               rsp_stall,
	output rsp_word_t               rsp_word,
	input  wire logic               cap_we,
	input  wire logic [FIELD_W-1:0] cap_wdata
);

	// cell 0 holds the top of stack; cell i holds the word i below it
	logic [WORD_W-1:0] word_w [DEPTH];
	logic [WORD_W-1:0] tap_w  [DEPTH];
	cell_ctl_t         ctl;

	// controller: count, capacity, peek walk counter and result register
	bls_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd_word  (cmd_word),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_word  (rsp_word),
		.cap_we    (cap_we),
		.cap_wdata (cap_wdata),
		.top_word  (word_w[0]),
		.top_tap   (tap_w[0]),
		.ctl       (ctl)
	);

	// the row: push shifts words down, pop shifts them up; the bottom cell
	// fills from zero on pop, which is never read as the count drops with it
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [WORD_W-1:0] up_word;
		logic [WORD_W-1:0] down_word;
		logic [WORD_W-1:0] down_tap;

		if (i == 0) begin : g_top
			assign up_word = cmd_word.push_value;
		end else begin : g_mid
			assign up_word = word_w[i-1];
		end

		if (i == DEPTH - 1) begin : g_bot
			assign down_word = '0;
			assign down_tap  = '0;
		end else begin : g_link
			assign down_word = word_w[i+1];
			assign down_tap  = tap_w[i+1];
		end

		bls_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.up_word   (up_word),
			.down_word (down_word),
			.down_tap  (down_tap),
			.word      (word_w[i]),
			.tap       (tap_w[i])
		);
	end

endmodule

`default_nettype wire

FILE: src/bls_cell.sv
// One stack cell: a stored word plus a tap register for the peek read path
`default_nettype none

module bls_cell import bls_pkg::*; (
	input  wire logic              clk,
	input  wire cell_ctl_t         ctl,
	input  wire logic [WORD_W-1:0] up_word,
	input  wire logic [WORD_W-1:0] down_word,
	input  wire logic [WORD_W-1:0] down_tap,
	output logic      [WORD_W-1:0] word,
	output logic      [WORD_W-1:0] tap
);

	logic [WORD_W-1:0] word_q;
	logic [WORD_W-1:0] tap_q;

	// push moves the row down, pop moves it up
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			word_q <= up_word;
		end else if (ctl.pop) begin
			word_q <= down_word;
		end
	end

	// tap row: snapshot of the words, then walked towards the top
	always_ff @(posedge clk) begin
		if (ctl.load_tap) begin
			tap_q <= word_q;
		end else if (ctl.shift_tap) begin
			tap_q <= down_tap;
		end
	end

	assign word = word_q;
	assign tap  = tap_q;

endmodule

`default_nettype wire

FILE: src/bls_ctrl.sv
// Stack controller: fill count, capacity, peek sequencing and result register
`default_nettype none

module bls_ctrl import bls_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cmd_valid,
	output logic                    cmd_stall,
	input  wire cmd_word_t          cmd_word,
	output logic                    rsp_valid,
	input  wire logic               rsp_stall,
	output rsp_word_t               rsp_word,
	input  wire logic               cap_we,
	input  wire logic [FIELD_W-1:0] cap_wdata,
	input  wire logic [WORD_W-1:0]  top_word,
	input  wire logic [WORD_W-1:0]  top_tap,
	output cell_ctl_t               ctl
);

	`include "assert_macros.svh"

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CMP_W = (CNT_W > FIELD_W) ? CNT_W : FIELD_W;

	state_t             state_q, state_d;
	logic [CNT_W-1:0]   count_q;
	logic [IDX_W-1:0]   peek_cnt_q;
	logic [FIELD_W-1:0] cap_q;
	logic               rsp_valid_q;
	rsp_word_t          rsp_q;

	logic               cmd_fire;
	logic               rsp_free;
	logic [CMP_W-1:0]   count_ext;
	logic [CMP_W-1:0]   pos_ext;
	logic [CMP_W-1:0]   cap_ext;
	logic [CMP_W-1:0]   cap_eff;
	logic               can_push;
	logic               pos_ok;
	logic               rsp_ld;
	rsp_word_t          rsp_d;

	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign cmd_stall = (state_q != S_IDLE) || !rsp_free;
	assign cmd_fire  = cmd_valid && !cmd_stall;

	assign count_ext = CMP_W'(count_q);
	assign pos_ext   = CMP_W'(cmd_word.depth_position);
	assign cap_ext   = CMP_W'(cap_q);

	// capacity of zero behaves as one, above DEPTH as DEPTH
	always_comb begin
		cap_eff = cap_ext;
		if (cap_q == '0) begin
			cap_eff = CMP_W'(1);
		end else if (cap_ext > CMP_W'(DEPTH)) begin
			cap_eff = CMP_W'(DEPTH);
		end
	end

	assign can_push = count_ext < cap_eff;
	assign pos_ok   = (cmd_word.depth_position != '0) && (pos_ext <= count_ext);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd_fire && cmd_word.command == CMD_PEEK && pos_ok) begin
					state_d = S_PEEK;
				end
			end
			S_PEEK: begin
				if (peek_cnt_q == '0 && rsp_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// cell controls and result
	always_comb begin
		ctl    = '0;
		rsp_ld = 1'b0;
		rsp_d.status      = STAT_OK;
		rsp_d.read_data   = '0;
		rsp_d.entry_count = count_ext[FIELD_W-1:0];
		unique case (state_q)
			S_IDLE: begin
				if (cmd_fire) begin
					rsp_ld = 1'b1;
					case (cmd_word.command)
						CMD_PUSH: begin
							if (can_push) begin
								ctl.push = 1'b1;
								rsp_d.entry_count = FIELD_W'(count_ext + CMP_W'(1));
							end else begin
								rsp_d.status = STAT_OVERFLOW;
							end
						end
						CMD_POP: begin
							if (count_q != '0) begin
								ctl.pop = 1'b1;
								rsp_d.read_data   = top_word;
								rsp_d.entry_count = FIELD_W'(count_ext - CMP_W'(1));
							end else begin
								rsp_d.status = STAT_EMPTY;
							end
						end
						CMD_PEEK: begin
							if (pos_ok) begin
								ctl.load_tap = 1'b1;
								rsp_ld = 1'b0;
							end else begin
								rsp_d.status = STAT_BAD_POS;
							end
						end
						default: ;
					endcase
				end
			end
			S_PEEK: begin
				if (peek_cnt_q != '0) begin
					ctl.shift_tap = 1'b1;
				end else if (rsp_free) begin
					rsp_ld = 1'b1;
					rsp_d.read_data = top_tap;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			peek_cnt_q  <= '0;
			cap_q       <= CAP_RESET;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.push) begin
				count_q <= count_q + CNT_W'(1);
			end else if (ctl.pop) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (ctl.load_tap) begin
				peek_cnt_q <= IDX_W'(pos_ext - CMP_W'(1));
			end else if (ctl.shift_tap) begin
				peek_cnt_q <= peek_cnt_q - IDX_W'(1);
			end
			if (cap_we) begin
				cap_q <= cap_wdata;
			end
			rsp_valid_q <= rsp_ld || (rsp_valid_q && rsp_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_ld) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_word  = rsp_q;

	`ASSERT_ALWAYS(a_count_bound, count_ext <= CMP_W'(DEPTH), "fill count beyond depth")
	`ASSERT_NEXT(a_push_inc, ctl.push, count_q == $past(count_q) + CNT_W'(1), "push lost")
	`ASSERT_NEXT(a_pop_dec, ctl.pop, count_q == $past(count_q) - CNT_W'(1), "pop lost")
	`ASSERT_NEXT(a_peek_walk, ctl.shift_tap, peek_cnt_q == $past(peek_cnt_q) - IDX_W'(1),
		"peek walk skipped")
	`ASSERT_ALWAYS(a_peek_blocks, state_q != S_PEEK || cmd_stall, "word taken during peek")

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the bounded LIFO stack with capacity register and peek

module tb;
	import bls_pkg::*;

	localparam int STACK_DEPTH = 16;
	localparam int QUIET_LIMIT = 2000;   // cycles with no word moving on either side
	localparam int TAIL_CYCLES = 40;     // idle tail after the last result has come back
	localparam int PHASES = 8;
	localparam int PHASE_WORDS = 100;

	// command code the block treats as a no-op
	localparam logic [1:0] CMD_NONE = 2'd3;

	typedef enum logic { ROW_WORD, ROW_CAP } row_kind_t;
	typedef enum logic [1:0] { MOOD_FILL, MOOD_DRAIN, MOOD_MIX } mood_t;
	typedef enum logic [1:0] { STALL_NONE, STALL_LIGHT, STALL_HEAVY } stall_mode_t;

	// one directed step: a word to send or a capacity to write
	typedef struct {
		row_kind_t kind;
		cmd_word_t word;
		logic typed;          // expected result given in the row itself
		rsp_word_t want;
		logic [FIELD_W-1:0] cap;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	cmd_word_t cmd_word = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_word_t rsp_word;
	logic cap_we = 1'b0;
	logic [FIELD_W-1:0] cap_wdata = '0;

	// shadow of the stack: words, fill level and capacity register
	logic signed [WORD_W-1:0] held_words [STACK_DEPTH];
	int held_count = 0;
	logic [FIELD_W-1:0] cap_reg = CAP_RESET;

	rsp_word_t pending_results [$];
	rsp_word_t awaited_rsp;
	plan_row_t directed_rows [$];

	int mismatches = 0;
	int words_sent = 0;
	int results_checked = 0;
	int cap_writes = 0;
	int status_seen [4] = '{0, 0, 0, 0};
	int quiet_cycles = 0;
	int burst_left = 0;
	logic steady_send = 1'b0;
	stall_mode_t stall_mode = STALL_NONE;
	int stall_left = 0;

	bounded_lifo_stack dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd_word  (cmd_word),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_word  (rsp_word),
		.cap_we    (cap_we),
		.cap_wdata (cap_wdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Applies one word to the shadow stack and returns the result it should give.
	// Capacity 0 behaves as 1, anything above the depth as the depth.
	function automatic rsp_word_t lifo_apply(input cmd_word_t w);
		rsp_word_t r;
		int lim;
		lim = (cap_reg == 0) ? 1 : (cap_reg > STACK_DEPTH) ? STACK_DEPTH : int'(cap_reg);
		r.status = STAT_OK;
		r.read_data = '0;
		case (w.command)
			CMD_PUSH: begin
				// a lowered capacity leaves held words alone; push just refuses
				if (held_count >= lim)
					r.status = STAT_OVERFLOW;
				else begin
					held_words[held_count] = w.push_value;
					held_count++;
				end
			end
			CMD_POP: begin
				if (held_count == 0)
					r.status = STAT_EMPTY;
				else begin
					held_count--;
					r.read_data = held_words[held_count];
				end
			end
			CMD_PEEK: begin
				// position 1 is the top; 0 and anything past the fill are refused
				if (w.depth_position == 0 || w.depth_position > held_count)
					r.status = STAT_BAD_POS;
				else
					r.read_data = held_words[held_count - w.depth_position];
			end
			default: ;
		endcase
		r.entry_count = FIELD_W'(held_count);
		return r;
	endfunction

	task automatic note_mismatch(input string what);
		$display("tb: mismatch at %0t ns: %s", $time, what);
		mismatches++;
	endtask

	// Presents one word, holds it until taken, then logs what should come back.
	task automatic send_word(input cmd_word_t w, input logic typed, input rsp_word_t typed_rsp);
		rsp_word_t modelled;
		cmd_valid <= 1'b1;
		cmd_word <= w;
		do @(posedge clk); while (cmd_stall);
		modelled = lifo_apply(w);
		pending_results.push_back(typed ? typed_rsp : modelled);
		words_sent++;
	endtask

	// Sender bursts: at the end of each burst, an optional gap with valid low.
	task automatic pace();
		int gap;
		if (burst_left > 0)
			burst_left--;
		else begin
			burst_left = $urandom_range(1, 12);
			gap = steady_send ? 0 : $urandom_range(0, 6);
			if (gap > 0) begin
				cmd_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Capacity is only written once every result in flight has come back.
	task automatic set_capacity(input logic [FIELD_W-1:0] v);
		cmd_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		cap_we <= 1'b1;
		cap_wdata <= v;
		@(posedge clk);
		cap_we <= 1'b0;
		cap_reg = v;
		cap_writes++;
	endtask

	task automatic add_word(input logic [1:0] cmd, input logic [WORD_W-1:0] val,
			input logic [FIELD_W-1:0] pos, input logic typed,
			input logic [1:0] st, input logic [FIELD_W-1:0] cnt);
		plan_row_t row;
		row.kind = ROW_WORD;
		row.word.command = cmd;
		row.word.push_value = val;
		row.word.depth_position = pos;
		row.typed = typed;
		row.want.status = st;
		row.want.read_data = '0;   // every typed row is a push, a refusal or the no-op
		row.want.entry_count = cnt;
		row.cap = '0;
		directed_rows.push_back(row);
	endtask

	task automatic add_cap(input logic [FIELD_W-1:0] v);
		plan_row_t row;
		row = '{kind: ROW_CAP, word: '0, typed: 1'b0, want: '0, cap: v};
		directed_rows.push_back(row);
	endtask

	// Receiver: stretches of no stall, light stall and heavy stall.
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= stall_mode_t'($urandom_range(0, 2));
			stall_left <= $urandom_range(20, 150);
		end else
			stall_left <= stall_left - 1;
		case (stall_mode)
			STALL_NONE: rsp_stall <= 1'b0;
			STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
			default: rsp_stall <= ($urandom_range(0, 3) != 0);
		endcase
	end

	// Result checker: oldest expectation against each word taken.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			status_seen[rsp_word.status]++;
			if (pending_results.size() == 0)
				note_mismatch($sformatf("unexpected result: status %0d data %0d count %0d",
					rsp_word.status, rsp_word.read_data, rsp_word.entry_count));
			else begin
				awaited_rsp = pending_results.pop_front();
				results_checked++;
				if (rsp_word.status !== awaited_rsp.status)
					note_mismatch($sformatf("status %0d, expected %0d",
						rsp_word.status, awaited_rsp.status));
				if (rsp_word.read_data !== awaited_rsp.read_data)
					note_mismatch($sformatf("read data %0d, expected %0d",
						rsp_word.read_data, awaited_rsp.read_data));
				if (rsp_word.entry_count !== awaited_rsp.entry_count)
					note_mismatch($sformatf("entry count %0d, expected %0d",
						rsp_word.entry_count, awaited_rsp.entry_count));
			end
		end
	end

	// Watchdog: too long with no word moving either way ends the run.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
				quiet_cycles <= 0;
			else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("tb: stalled for %0d cycles", QUIET_LIMIT);
				$display("tb: done, errors");
				$finish;
			end else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		logic [FIELD_W-1:0] cap_plan [PHASES];
		mood_t mood_plan [PHASES];
		cmd_word_t w;
		int ph;
		int n;
		int roll;
		int push_cut;
		int pop_cut;

		cap_plan = '{5'd16, 5'd31, 5'd1, 5'd17, 5'd0, 5'd8, 5'd0, 5'd16};
		cap_plan[6] = FIELD_W'($urandom_range(0, 31));
		mood_plan = '{MOOD_FILL, MOOD_FILL, MOOD_MIX, MOOD_FILL,
			MOOD_DRAIN, MOOD_MIX, MOOD_FILL, MOOD_DRAIN};

		// Directed part. Refusals, pushes and the no-op carry their result in the row;
		// reads are left to the shadow stack.
		add_word(CMD_POP,  32'h0000_0000, 5'd0,  1'b1, STAT_EMPTY,   5'd0);
		add_word(CMD_PEEK, 32'h0000_0000, 5'd0,  1'b1, STAT_BAD_POS, 5'd0);
		add_word(CMD_PEEK, 32'hFFFF_FFFF, 5'd1,  1'b1, STAT_BAD_POS, 5'd0);
		add_word(CMD_PUSH, 32'h7FFF_FFFF, 5'd31, 1'b1, STAT_OK,      5'd1);
		add_word(CMD_PUSH, 32'h8000_0000, 5'd0,  1'b1, STAT_OK,      5'd2);
		add_word(CMD_PUSH, 32'hFFFF_FFFF, 5'd16, 1'b1, STAT_OK,      5'd3);
		add_word(CMD_PEEK, 32'h0000_0000, 5'd1,  1'b0, STAT_OK,      5'd0);
		add_word(CMD_PEEK, 32'h0000_0000, 5'd3,  1'b0, STAT_OK,      5'd0);
		add_word(CMD_PEEK, 32'h0000_0000, 5'd4,  1'b1, STAT_BAD_POS, 5'd3);
		add_word(CMD_PEEK, 32'h0000_0000, 5'd31, 1'b1, STAT_BAD_POS, 5'd3);
		add_word(CMD_NONE, 32'h1234_5678, 5'd5,  1'b1, STAT_OK,      5'd3);
		add_word(CMD_POP,  32'h0000_0000, 5'd0,  1'b0, STAT_OK,      5'd0);
		add_cap(5'd2);   // capacity now equals the fill
		add_word(CMD_PUSH, 32'h0000_0001, 5'd0,  1'b1, STAT_OVERFLOW, 5'd2);
		add_cap(5'd1);   // below the fill: held words stay
		add_word(CMD_PUSH, 32'h0000_0002, 5'd0,  1'b1, STAT_OVERFLOW, 5'd2);
		add_word(CMD_POP,  32'h0000_0000, 5'd0,  1'b0, STAT_OK,       5'd0);
		add_word(CMD_PUSH, 32'h0000_0003, 5'd0,  1'b1, STAT_OVERFLOW, 5'd1);
		add_word(CMD_PEEK, 32'h0000_0000, 5'd1,  1'b0, STAT_OK,       5'd0);
		add_word(CMD_POP,  32'h0000_0000, 5'd0,  1'b0, STAT_OK,       5'd0);
		add_cap(5'd0);   // zero acts as one
		add_word(CMD_PUSH, 32'h5A5A_5A5A, 5'd0,  1'b1, STAT_OK,       5'd1);
		add_word(CMD_PUSH, 32'hA5A5_A5A5, 5'd0,  1'b1, STAT_OVERFLOW, 5'd1);
		add_word(CMD_POP,  32'h0000_0000, 5'd0,  1'b0, STAT_OK,       5'd0);
		add_word(CMD_POP,  32'h0000_0000, 5'd0,  1'b1, STAT_EMPTY,    5'd0);
		add_cap(5'd31);  // above the depth acts as the depth
		add_word(CMD_PUSH, 32'h0000_0000, 5'd31, 1'b1, STAT_OK,       5'd1);
		add_word(CMD_PEEK, 32'h0000_0000, 5'd1,  1'b0, STAT_OK,       5'd0);
		add_word(CMD_POP,  32'h0000_0000, 5'd0,  1'b0, STAT_OK,       5'd0);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_CAP)
				set_capacity(directed_rows[i].cap);
			else begin
				send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want);
				pace();
			end
		end

		// Random part: each phase sets a capacity and leans towards filling,
		// draining or a mix, so the stack runs full and empty many times.
		for (ph = 0; ph < PHASES; ph++) begin
			set_capacity(cap_plan[ph]);
			steady_send = (ph % 3 == 1);
			case (mood_plan[ph])
				MOOD_FILL: begin
					push_cut = 55;
					pop_cut = 70;
				end
				MOOD_DRAIN: begin
					push_cut = 20;
					pop_cut = 60;
				end
				default: begin
					push_cut = 38;
					pop_cut = 68;
				end
			endcase
			for (n = 0; n < PHASE_WORDS; n++) begin
				roll = $urandom_range(0, 99);
				w.push_value = $urandom;
				w.depth_position = FIELD_W'($urandom_range(0, 31));
				if ($urandom_range(0, 7) == 0) begin
					case ($urandom_range(0, 3))
						0: w.push_value = 32'h0000_0000;
						1: w.push_value = 32'hFFFF_FFFF;
						2: w.push_value = 32'h8000_0000;
						default: w.push_value = 32'h7FFF_FFFF;
					endcase
				end
				if (roll < push_cut)
					w.command = CMD_PUSH;
				else if (roll < pop_cut)
					w.command = CMD_POP;
				else if (roll < 97) begin
					w.command = CMD_PEEK;
					// mostly a position that is held, any depth
					if (held_count > 0 && $urandom_range(0, 9) < 8)
						w.depth_position = FIELD_W'($urandom_range(1, held_count));
				end else
					w.command = CMD_NONE;
				send_word(w, 1'b0, '0);
				pace();
			end
		end

		cmd_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("tb: %0d words sent, %0d results checked, %0d capacity writes",
			words_sent, results_checked, cap_writes);
		$display("tb: results seen: ok %0d, overflow %0d, empty %0d, bad position %0d",
			status_seen[STAT_OK], status_seen[STAT_OVERFLOW],
			status_seen[STAT_EMPTY], status_seen[STAT_BAD_POS]);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
